FILE: hw/rtl/rde_pkg.sv
package rde_pkg;

   // Default depth of the digit stack and the largest radix the datapath accepts.
   localparam int MAX_DIGITS_DEF = 32;
   localparam int MAX_RADIX      = 16;

   // Fixed field widths.
   localparam int VALUE_W    = 32;
   localparam int CHAR_W     = 8;
   localparam int RADIX_W    = 5;
   localparam int DIGIT_W    = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam int BYTE_IDX_W = 2;

   // The radix reset value and the character sent ahead of a negative value.
   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
   localparam logic [CHAR_W-1:0]  MINUS_SIGN  = 8'd45;

   // Configuration register indices.
   localparam logic [CSR_IDX_W-1:0] CSR_RADIX        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_HIGH = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture a new value and start the division
      logic div_step;    // divide one byte of the working quotient
      logic load_sign;   // place the minus sign in the output register
      logic pop;         // read the next digit off the stack
      logic load_digit;  // place the symbol of the popped digit in the output register
   } rde_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic digit_end;   // the current step finishes a digit
      logic quot_zero;   // the quotient left after this step is zero
      logic negative;    // the value being converted is negative
      logic out_free;    // the output register can take a character this cycle
      logic count_zero;  // no digits are left on the stack
   } rde_status_type;

endpackage

FILE: hw/rtl/rde_channels.sv
// Input channel: one signed value per transaction.
interface rde_req_if;
   import rde_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// Result channel: one character per transaction, the last one flagged.
interface rde_rsp_if;
   import rde_pkg::*;

   logic               valid;
   logic               ready;
   logic [CHAR_W-1:0]  character;
   logic               last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

// Register write channel.
interface rde_csr_if;
   import rde_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/radix_digit_emitter_top.sv
// Converts a signed 32-bit value into its digits in a configured radix, most
// significant digit first, each digit mapped to a byte from a symbol table.
// req_bus carries one value per transaction; rsp_bus carries one character per
// transaction with last set on the final character; a negative value is
// preceded by a minus sign. csr_bus writes the radix (index 0, clamped to
// 2..16) and the two halves of the symbol table (indices 1 and 2); it is
// always ready and should only be written while the block is idle.
// Each digit is found by dividing the quotient left byte by byte, from its
// most significant non-zero byte down, and is pushed on the digit stack.
// After the last division step a negative value has its minus sign loaded
// into the output register; then the top digit is read off the stack and
// loaded. Digits then follow at one per cycle while the receiver is ready.
// A new value is accepted in the cycle after the last character is loaded,
// even while that character waits. At reset the radix returns to 10, the
// symbol table to zero and the output register is emptied. A stalled
// receiver holds the current character and stops the controller; nothing
// is dropped.
module radix_digit_emitter_top #(
   parameter int MAX_DIGITS = rde_pkg::MAX_DIGITS_DEF
) (
   input logic         clock,
   input logic         reset,
   rde_req_if.sink     req_bus,
   rde_rsp_if.source   rsp_bus,
   rde_csr_if.sink     csr_bus
);
   import rde_pkg::*;

   rde_cmd_type    cmd;
   rde_status_type status;

   // Sequencer for division, sign and emission.
   rde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Registers, byte divider, digit stack and output register.
   rde_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_value     (req_bus.value),
      .csr_valid     (csr_bus.valid),
      .csr_index     (csr_bus.index),
      .csr_data      (csr_bus.data),
      .csr_ready     (csr_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_character (rsp_bus.character),
      .rsp_last      (rsp_bus.last),
      .rsp_ready     (rsp_bus.ready)
   );

endmodule

FILE: hw/rtl/rde_ram.sv
module rde_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/rde_datapath.sv
module rde_datapath #(
   parameter int MAX_DIGITS = rde_pkg::MAX_DIGITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rde_pkg::rde_cmd_type                cmd,
   output rde_pkg::rde_status_type             status,
   input  logic signed [rde_pkg::VALUE_W-1:0]  req_value,
   input  logic                                csr_valid,
   input  logic [rde_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rde_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                csr_ready,
   output logic                                rsp_valid,
   output logic [rde_pkg::CHAR_W-1:0]          rsp_character,
   output logic                                rsp_last,
   input  logic                                rsp_ready
);
   import rde_pkg::*;

   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int ADDR_W = $clog2(MAX_DIGITS);
   localparam logic [CNT_W-1:0] CountFull = CNT_W'(MAX_DIGITS);
   localparam logic [RADIX_W-1:0] RadixMax = RADIX_W'(MAX_RADIX);

   // Configuration registers.
   logic [RADIX_W-1:0]    radix_ff;
   logic [CSR_DATA_W-1:0] sym_lo_ff;
   logic [CSR_DATA_W-1:0] sym_hi_ff;

   // Division state.
   logic [VALUE_W-1:0]    quot_ff, quot_in;
   logic [DIGIT_W-1:0]    rem_ff, rem_in;
   logic [BYTE_IDX_W-1:0] idx_ff, idx_in;
   logic [BYTE_IDX_W-1:0] top_ff, top_in;
   logic                  neg_ff, neg_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   // Output register.
   logic                  out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]     char_ff, char_in;
   logic                  last_ff, last_in;

   logic [VALUE_W-1:0]    raw;
   logic [VALUE_W-1:0]    magnitude;
   logic [BYTE_IDX_W-1:0] mag_top;
   logic [RADIX_W-1:0]    radix_eff;
   logic [CHAR_W-1:0]     byte_cur;
   logic [CHAR_W-1:0]     qbyte;
   logic [DIGIT_W-1:0]    rem_nx;
   logic                  digit_end;
   logic                  quot_zero;
   logic                  stack_we;
   logic [CNT_W-1:0]      count_dec;
   logic [DIGIT_W-1:0]    stack_rdata;
   logic [2*CSR_DATA_W-1:0] sym_table;
   logic [CHAR_W-1:0]     symbol;
   logic                  out_free;
   logic [BYTE_IDX_W-1:0] next_top;

   // Register writes are always taken; unknown indices are ignored.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff  <= RADIX_RESET;
         sym_lo_ff <= '0;
         sym_hi_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RADIX:        radix_ff  <= csr_data[RADIX_W-1:0];
            CSR_SYMBOLS_LOW:  sym_lo_ff <= csr_data;
            CSR_SYMBOLS_HIGH: sym_hi_ff <= csr_data;
            default:          ;
         endcase
      end
   end

   // Radix clamped into the supported range.
   always_comb begin
      if (radix_ff < RADIX_W'(2)) begin
         radix_eff = RADIX_W'(2);
      end else if (radix_ff > RadixMax) begin
         radix_eff = RadixMax;
      end else begin
         radix_eff = radix_ff;
      end
   end

   // Magnitude of the incoming value, taken as unsigned so the most negative value works.
   assign raw       = req_value;
   assign magnitude = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;

   // Most significant non-zero byte; leading zero bytes need no division.
   always_comb begin
      if (magnitude[31:24] != '0) begin
         mag_top = 2'd3;
      end else if (magnitude[23:16] != '0) begin
         mag_top = 2'd2;
      end else if (magnitude[15:8] != '0) begin
         mag_top = 2'd1;
      end else begin
         mag_top = 2'd0;
      end
   end

   // Restoring division of one byte by the radix, eight bits in one pass.
   assign byte_cur = quot_ff[{idx_ff, 3'b000} +: CHAR_W];

   always_comb begin
      logic [DIGIT_W-1:0] r;
      logic [DIGIT_W:0]   t;
      r     = rem_ff;
      qbyte = '0;
      for (int i = CHAR_W - 1; i >= 0; i--) begin
         t = {r, byte_cur[i]};
         if (t >= radix_eff) begin
            t        = t - radix_eff;
            qbyte[i] = 1'b1;
         end
         r = t[DIGIT_W-1:0];
      end
      rem_nx = r;
   end

   assign digit_end = (idx_ff == '0);
   assign quot_zero = (quot_ff[VALUE_W-1:CHAR_W] == '0) && (qbyte == '0);

   // Each digit shortens the quotient by at most one byte.
   assign next_top = ((quot_ff[{top_ff, 3'b000} +: CHAR_W] == '0) && (top_ff != '0))
                     ? (top_ff - BYTE_IDX_W'(1)) : top_ff;

   assign stack_we  = cmd.div_step && digit_end && (count_ff != CountFull);
   assign count_dec = count_ff - CNT_W'(1);

   // Working quotient, remainder, byte pointer and digit count.
   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      idx_in   = idx_ff;
      top_in   = top_ff;
      neg_in   = neg_ff;
      count_in = count_ff;
      if (cmd.load) begin
         quot_in  = magnitude;
         rem_in   = '0;
         idx_in   = mag_top;
         top_in   = mag_top;
         neg_in   = raw[VALUE_W-1];
         count_in = '0;
      end else if (cmd.div_step) begin
         quot_in[{idx_ff, 3'b000} +: CHAR_W] = qbyte;
         if (digit_end) begin
            rem_in = '0;
            idx_in = next_top;
            top_in = next_top;
            if (count_ff != CountFull) begin
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            rem_in = rem_nx;
            idx_in = idx_ff - BYTE_IDX_W'(1);
         end
      end else if (cmd.pop) begin
         count_in = count_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quot_ff  <= '0;
         count_ff <= '0;
      end else begin
         quot_ff  <= quot_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      idx_ff <= idx_in;
      top_ff <= top_in;
      neg_ff <= neg_in;
   end

   // Digit stack, least significant digit at the lowest address.
   rde_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (MAX_DIGITS)
   ) u_stack (
      .clock (clock),
      .we    (stack_we),
      .waddr (count_ff[ADDR_W-1:0]),
      .wdata (rem_nx),
      .re    (cmd.pop),
      .raddr (count_dec[ADDR_W-1:0]),
      .rdata (stack_rdata)
   );

   // Symbol lookup of the popped digit.
   assign sym_table = {sym_hi_ff, sym_lo_ff};
   assign symbol    = sym_table[{stack_rdata, 3'b000} +: CHAR_W];

   // Output register; it frees up in the cycle its transaction completes.
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      if (cmd.load_sign) begin
         out_valid_in = 1'b1;
         char_in      = MINUS_SIGN;
         last_in      = 1'b0;
      end else if (cmd.load_digit) begin
         out_valid_in = 1'b1;
         char_in      = symbol;
         last_in      = (count_ff == '0);
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

   assign status.digit_end  = digit_end;
   assign status.quot_zero  = quot_zero;
   assign status.negative   = neg_ff;
   assign status.out_free   = out_free;
   assign status.count_zero = (count_ff == '0);

endmodule

FILE: hw/rtl/rde_ctrl.sv
module rde_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  rde_pkg::rde_status_type status,
   output rde_pkg::rde_cmd_type    cmd
);
   import rde_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SIGN,
      ST_READ,
      ST_LOAD
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands to the datapath.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.digit_end && status.quot_zero) begin
               state_in = status.negative ? ST_SIGN : ST_READ;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.load_sign = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            cmd.pop  = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            // Send the popped digit and fetch the next one in the same cycle.
            if (status.out_free) begin
               cmd.load_digit = 1'b1;
               if (status.count_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.pop = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/rde_checker.sv
module rde_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [rde_pkg::CHAR_W-1:0]  rsp_character,
   input logic                        rsp_last
);

   // Once a value is taken the block is busy with it.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input still ready right after a transaction");

   // No character can appear in the cycle after a value is taken.
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result appeared too early after an input transaction");

   // A value still being emitted blocks the input.
   a_busy_mid_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> !req_ready)
      else $error("input ready while a value is only partly emitted");

   // A stalled character is held unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_character) && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule

bind radix_digit_emitter_top rde_checker u_rde_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_character (rsp_bus.character),
   .rsp_last      (rsp_bus.last)
);

FILE: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rde_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SETTLE       = 6;
   localparam int DRAIN_CYCLES = 40;
   localparam int REPORT_MAX   = 10;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 25;
   localparam int IDLE_PERCENT = 20;

   // The one index that selects no register.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // Symbol tables spelling the digits 0 to 9 and A to F in ASCII.
   localparam logic [CSR_DATA_W-1:0] ASCII_LOW  = 64'h3736_3534_3332_3130;
   localparam logic [CSR_DATA_W-1:0] ASCII_HIGH = 64'h4645_4443_4241_3938;

   // Radix settings walked by the first eight random phases, from index 0 up.
   localparam logic [7:0][RADIX_W-1:0] RADIX_PICKS =
      {5'd2, 5'd16, 5'd0, 5'd31, 5'd3, 5'd10, 5'd1, 5'd17};

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
   } sym_out_type;

   localparam sym_out_type NO_CHAR = '0;

   // A count of zero means the characters come from the predictor.
   typedef struct packed {
      logic [1:0]        count;
      sym_out_type [2:0] chars;
   } value_note_type;

   typedef struct packed {
      logic                  is_cfg;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
      value_note_type        note;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_take  = 1'b0;
   logic                      csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = CSR_RADIX;
   logic [CSR_DATA_W-1:0]     csr_data  = '0;

   bit calm = 1'b0;
   int failures = 0;
   int cycle_count = 0;

   // Shadow copy of the configuration registers.
   logic [RADIX_W-1:0]    cfg_radix    = RADIX_RESET;
   logic [CSR_DATA_W-1:0] cfg_sym_low  = '0;
   logic [CSR_DATA_W-1:0] cfg_sym_high = '0;

   sym_out_type    chars_due[$];
   value_note_type values_in_flight[$];
   plan_row_type   plan[$];

   rde_req_if req_ch();
   rde_rsp_if rsp_ch();
   rde_csr_if csr_ch();

   assign req_ch.valid = req_valid;
   assign req_ch.value = req_value;
   assign rsp_ch.ready = rsp_take;
   assign csr_ch.valid = csr_valid;
   assign csr_ch.index = csr_index;
   assign csr_ch.data  = csr_data;

   radix_digit_emitter_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .csr_bus (csr_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Works out the characters of one value under the current configuration
   // and queues them, minus sign first, most significant digit next.
   function automatic void spell_value(input logic [VALUE_W-1:0] raw);
      logic [VALUE_W-1:0]      mag;
      logic [VALUE_W-1:0]      base;
      logic [DIGIT_W-1:0]      digits [0:MAX_DIGITS_DEF-1];
      logic [2*CSR_DATA_W-1:0] glyphs;
      int                      n;
      glyphs = {cfg_sym_high, cfg_sym_low};
      if (cfg_radix < 2) begin
         base = 2;
      end else if (cfg_radix > MAX_RADIX) begin
         base = MAX_RADIX;
      end else begin
         base = VALUE_W'(cfg_radix);
      end
      mag = raw[VALUE_W-1] ? -raw : raw;
      n = 0;
      do begin
         if (n < MAX_DIGITS_DEF) begin
            digits[n] = DIGIT_W'(mag % base);
            n++;
         end
         mag = mag / base;
      end while (mag != 0);
      if (raw[VALUE_W-1]) begin
         chars_due.push_back({MINUS_SIGN, 1'b0});
      end
      for (int i = n - 1; i >= 0; i--) begin
         chars_due.push_back({glyphs[digits[i]*CHAR_W +: CHAR_W], i == 0});
      end
   endfunction

   function automatic void report_failure(input string msg);
      failures++;
      if (failures <= REPORT_MAX) begin
         $display("%s", msg);
      end
   endfunction

   function automatic plan_row_type cfg_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] data);
      plan_row_type r;
      r = '0;
      r.is_cfg = 1'b1;
      r.index = idx;
      r.data = data;
      return r;
   endfunction

   // A value row; with n above zero the first n characters are typed in.
   function automatic plan_row_type val_row(input logic [VALUE_W-1:0] v, input int n,
                                            input sym_out_type a, input sym_out_type b,
                                            input sym_out_type c);
      plan_row_type r;
      r = '0;
      r.data = {{(CSR_DATA_W-VALUE_W){1'b0}}, v};
      r.note.count = 2'(n);
      r.note.chars = {c, b, a};
      return r;
   endfunction

   // Presents one value, idling at random beforehand, and returns once the
   // transaction has been accepted. Valid stays high for a following item.
   task automatic send_value(input logic [VALUE_W-1:0] v, input value_note_type note);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         req_value <= $urandom;
         @(posedge clock);
      end
      values_in_flight.push_back(note);
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_quiet();
      while (values_in_flight.size() != 0 || chars_due.size() != 0) @(posedge clock);
   endtask

   // Register writes happen only once the block has emptied its output.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      wait_quiet();
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Receiver: refuses a character at random about 20 percent of the time, except while calm.
   always @(posedge clock) begin
      rsp_take <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Monitor: checks each emitted character, predicts on each accepted value
   // and tracks register writes.
   always @(posedge clock) begin
      value_note_type note;
      sym_out_type    want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (chars_due.size() == 0) begin
               report_failure($sformatf("cycle %0d: unexpected character %h last %b",
                                        cycle_count, rsp_ch.character, rsp_ch.last));
            end else begin
               want = chars_due.pop_front();
               if (rsp_ch.character !== want.character || rsp_ch.last !== want.last) begin
                  report_failure($sformatf(
                     "cycle %0d: character exp %h got %h, last exp %b got %b",
                     cycle_count, want.character, rsp_ch.character, want.last,
                     rsp_ch.last));
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            note = values_in_flight.pop_front();
            if (note.count == 0) begin
               spell_value(req_ch.value);
            end else begin
               for (int i = 0; i < note.count; i++) begin
                  chars_due.push_back(note.chars[i]);
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_RADIX:        cfg_radix = csr_ch.data[RADIX_W-1:0];
               CSR_SYMBOLS_LOW:  cfg_sym_low = csr_ch.data;
               CSR_SYMBOLS_HIGH: cfg_sym_high = csr_ch.data;
               default: ;
            endcase
         end
      end
   end

   initial begin
      logic [VALUE_W-1:0] v;
      // Directed part: reset state, zero symbols, clamping of the radix,
      // the most negative and most positive values and an ignored index.
      plan.push_back(val_row(0, 1, {8'h00, 1'b1}, NO_CHAR, NO_CHAR));
      plan.push_back(val_row(-1, 2, {MINUS_SIGN, 1'b0}, {8'h00, 1'b1}, NO_CHAR));
      plan.push_back(val_row(32'h7FFF_FFFF, 0, NO_CHAR, NO_CHAR, NO_CHAR));
      plan.push_back(cfg_row(CSR_SYMBOLS_LOW, ASCII_LOW));
      plan.push_back(cfg_row(CSR_SYMBOLS_HIGH, ASCII_HIGH));
      plan.push_back(val_row(0, 1, {"0", 1'b1}, NO_CHAR, NO_CHAR));
      plan.push_back(val_row(-1, 2, {MINUS_SIGN, 1'b0}, {"1", 1'b1}, NO_CHAR));
      plan.push_back(val_row(9, 1, {"9", 1'b1}, NO_CHAR, NO_CHAR));
      plan.push_back(val_row(32'h8000_0000, 0, NO_CHAR, NO_CHAR, NO_CHAR));
      plan.push_back(val_row(32'h7FFF_FFFF, 0, NO_CHAR, NO_CHAR, NO_CHAR));
      plan.push_back(cfg_row(CSR_RADIX, 64'd0));
      plan.push_back(val_row(5, 3, {"1", 1'b0}, {"0", 1'b0}, {"1", 1'b1}));
      plan.push_back(val_row(32'h8000_0000, 0, NO_CHAR, NO_CHAR, NO_CHAR));
      plan.push_back(cfg_row(CSR_RADIX, 64'd1));
      plan.push_back(val_row(-2, 3, {MINUS_SIGN, 1'b0}, {"1", 1'b0}, {"0", 1'b1}));
      plan.push_back(val_row(32'h7FFF_FFFF, 0, NO_CHAR, NO_CHAR, NO_CHAR));
      plan.push_back(cfg_row(CSR_RADIX, 64'hFFFF_FFFF_FFFF_FFF0));
      plan.push_back(val_row(255, 2, {"F", 1'b0}, {"F", 1'b1}, NO_CHAR));
      plan.push_back(val_row(32'hDEAD_BEEF, 0, NO_CHAR, NO_CHAR, NO_CHAR));
      plan.push_back(cfg_row(CSR_RADIX, 64'd31));
      plan.push_back(val_row(32'h8000_0000, 0, NO_CHAR, NO_CHAR, NO_CHAR));
      plan.push_back(cfg_row(CSR_RADIX, 64'd17));
      plan.push_back(val_row(-15, 2, {MINUS_SIGN, 1'b0}, {"F", 1'b1}, NO_CHAR));
      plan.push_back(cfg_row(CSR_UNUSED, '1));
      plan.push_back(val_row(8'hAB, 2, {"A", 1'b0}, {"B", 1'b1}, NO_CHAR));
      plan.push_back(cfg_row(CSR_RADIX, 64'd3));
      plan.push_back(val_row(32'h8000_0000, 0, NO_CHAR, NO_CHAR, NO_CHAR));
      plan.push_back(val_row(32'h7FFF_FFFF, 0, NO_CHAR, NO_CHAR, NO_CHAR));
      plan.push_back(cfg_row(CSR_SYMBOLS_LOW, '1));
      plan.push_back(cfg_row(CSR_SYMBOLS_HIGH, '0));
      plan.push_back(cfg_row(CSR_RADIX, 64'd16));
      plan.push_back(val_row(32'h0123_4567, 0, NO_CHAR, NO_CHAR, NO_CHAR));
      plan.push_back(val_row(32'h89AB_CDEF, 0, NO_CHAR, NO_CHAR, NO_CHAR));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            write_register(plan[i].index, plan[i].data);
         end else begin
            send_value(plan[i].data[VALUE_W-1:0], plan[i].note);
         end
      end

      // Random phases: a fresh configuration, then values of mixed magnitude.
      // One phase runs with neither side idling.
      for (int phase = 0; phase < PHASES; phase++) begin
         write_register(CSR_RADIX, phase < 8 ? {59'd0, RADIX_PICKS[phase]}
                                             : 64'($urandom_range(0, 31)));
         if (phase % 2 == 0) begin
            write_register(CSR_SYMBOLS_LOW, ASCII_LOW);
            write_register(CSR_SYMBOLS_HIGH, ASCII_HIGH);
         end else begin
            write_register(CSR_SYMBOLS_LOW, {$urandom, $urandom});
            write_register(CSR_SYMBOLS_HIGH, {$urandom, $urandom});
         end
         calm = (phase == 3);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            case ($urandom_range(0, 7)) inside
               0, 1: v = $urandom;
               2: v = $urandom_range(0, 1000);
               3: v = -$urandom_range(1, 1000);
               4: v = $urandom >> $urandom_range(0, 31);
               5: v = -($urandom >> $urandom_range(0, 31));
               6: begin
                  case ($urandom_range(0, 3))
                     0: v = 32'h8000_0000;
                     1: v = 32'h7FFF_FFFF;
                     2: v = '0;
                     default: v = '1;
                  endcase
               end
               default: v = $urandom_range(0, 40) - 20;
            endcase
            send_value(v, '0);
         end
         calm = 1'b0;
      end

      // Drain, then watch a while longer for stray characters.
      req_valid <= 1'b0;
      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
